[rtl/page_pool_allocator_top_defines.svh]
// ----------------------------------------------------------------------------
// Page pool allocator assertion macros
// Shared concurrent assertion forms for the allocator top level.
// ----------------------------------------------------------------------------
`ifndef PAGE_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PPA_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("page pool allocator assertion failed");

// next-cycle implication
`define PPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("page pool allocator assertion failed");

`endif

[rtl/ppa_pkg.sv]
// ----------------------------------------------------------------------------
// Page pool allocator package
// Types, codes and helpers shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package ppa_pkg;

  localparam int unsigned POOL_PAGES_DEF   = 256;
  localparam int unsigned SIZE_CLASSES_DEF = 4;
  localparam int unsigned PAGE_BITS_DEF    = 12;

  localparam int unsigned ABS_W   = 20;
  localparam int unsigned BYTES_W = 21;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned ADDR_W  = 3;

  localparam logic REG_POOL_BASE = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_NOT_START = 3'd3,
    ST_ZERO      = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_EMIT,
    OP_A_CLS,
    OP_A_P,
    OP_A_NEXT,
    OP_A_HIT,
    OP_A_FIN,
    OP_U1,
    OP_U2,
    OP_AP0,
    OP_AP1,
    OP_F_INIT,
    OP_F_RD,
    OP_F_INC,
    OP_F_END,
    OP_F_RDN,
    OP_F_ADDN,
    OP_F_OWN0,
    OP_F_OWNP,
    OP_F_RDO,
    OP_F_SELF,
    OP_F_OSUM,
    OP_F_WO
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_ACLS,
    S_AP,
    S_ACHK,
    S_AU1,
    S_AU2,
    S_AA0,
    S_AA1,
    S_AFIN,
    S_AEMIT,
    S_FSCAN,
    S_FCHK,
    S_FNX,
    S_FNXC,
    S_FU1,
    S_FU2,
    S_FPV,
    S_FPVC,
    S_FOWN,
    S_FOC,
    S_OU1,
    S_OU2,
    S_FOSUM,
    S_FOA0,
    S_FOA1,
    S_FIA0,
    S_FIA1,
    S_FOW
  } state_e;

  typedef struct packed {
    op_e     op;
    status_e st;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero;
    logic outside;
    logic no_start;
    logic cls_end;
    logic p_valid;
    logic fit;
    logic rest_nz;
    logic end_found;
    logic has_next;
    logic next_free;
    logic idx_nz;
    logic prev_open;
    logic owner_ne;
    logic owner_small;
    logic own_more;
    logic clr_last;
  } sts_t;

  function automatic logic [31:0] class_of(input logic [31:0] n, input logic [31:0] sc);
    logic [31:0] r;
    if (n == 32'd0) begin
      r = 32'd0;
    end else if (n - 32'd1 >= sc) begin
      r = sc - 32'd1;
    end else begin
      r = n - 32'd1;
    end
    return r;
  endfunction

endpackage

[rtl/page_pool_allocator_top.sv]
// ----------------------------------------------------------------------------
// Page pool allocator
// Run allocator over a page pool with size-class free lists and coalescing.
// ----------------------------------------------------------------------------
// After reset the block sweeps its page tables with busy high. A transaction
// is taken when start is high and busy is low; its result appears on done_o
// for exactly one cycle and cannot be held off. Allocate visits free list
// entries and passes empty size classes in turn; free scans pages to the
// run's end mark and then rewrites the owner of each page of the merged run.
// Each page table has a single read port and a single write port.
module page_pool_allocator_top #(
  parameter int unsigned POOL_PAGES   = ppa_pkg::POOL_PAGES_DEF,
  parameter int unsigned SIZE_CLASSES = ppa_pkg::SIZE_CLASSES_DEF,
  parameter int unsigned PAGE_BITS    = ppa_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppa_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppa_pkg::APB_W-1:0]   pwdata,
  output logic [ppa_pkg::APB_W-1:0]   prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func_i,
  input  logic [ppa_pkg::BYTES_W-1:0] size_bytes_i,
  input  logic [ppa_pkg::ABS_W-1:0]   free_page_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [ppa_pkg::ABS_W-1:0]   page_o,
  output logic [ppa_pkg::CNT_W-1:0]   page_count_o,
  output logic [ppa_pkg::CNT_W-1:0]   free_total_o
);

  `include "page_pool_allocator_top_defines.svh"

  logic [ppa_pkg::ABS_W-1:0] pool_base_q;
  logic                      reg_sel;
  logic                      res_fail;
  logic                      res_empty;
  logic                      res_legal;
  ppa_pkg::cmd_t             cmd;
  ppa_pkg::sts_t             sts;

  assign reg_sel = (paddr[2] == ppa_pkg::REG_POOL_BASE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? ppa_pkg::APB_W'(pool_base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      pool_base_q <= pwdata[ppa_pkg::ABS_W-1:0];
    end
  end

  ppa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  ppa_dp #(
    .POOL_PAGES   (POOL_PAGES),
    .SIZE_CLASSES (SIZE_CLASSES),
    .PAGE_BITS    (PAGE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pool_base_i  (pool_base_q),
    .func_i       (func_i),
    .size_bytes_i (size_bytes_i),
    .free_page_i  (free_page_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .page_o       (page_o),
    .page_count_o (page_count_o),
    .free_total_o (free_total_o)
  );

  assign res_fail  = done_o && (status_o != ppa_pkg::ST_OK);
  assign res_empty = (page_o == '0) && (page_count_o == '0);
  assign res_legal = (status_o == ppa_pkg::ST_OK) || (status_o == ppa_pkg::ST_NO_FIT) ||
                     (status_o == ppa_pkg::ST_OUTSIDE) || (status_o == ppa_pkg::ST_NOT_START) ||
                     (status_o == ppa_pkg::ST_ZERO);

  `PPA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `PPA_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  `PPA_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, res_fail, res_empty)
  `PPA_ASSERT_NOW(a_status_code, clk_i, rst_ni, done_o, res_legal)

endmodule

[rtl/ppa_dp.sv]
// ----------------------------------------------------------------------------
// Page pool allocator datapath
// Page tables, free list heads, work registers and the result register.
// ----------------------------------------------------------------------------
module ppa_dp #(
  parameter int unsigned POOL_PAGES   = ppa_pkg::POOL_PAGES_DEF,
  parameter int unsigned SIZE_CLASSES = ppa_pkg::SIZE_CLASSES_DEF,
  parameter int unsigned PAGE_BITS    = ppa_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ppa_pkg::cmd_t               cmd_i,
  output ppa_pkg::sts_t               sts_o,
  input  logic [ppa_pkg::ABS_W-1:0]   pool_base_i,
  input  logic                        func_i,
  input  logic [ppa_pkg::BYTES_W-1:0] size_bytes_i,
  input  logic [ppa_pkg::ABS_W-1:0]   free_page_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [ppa_pkg::ABS_W-1:0]   page_o,
  output logic [ppa_pkg::CNT_W-1:0]   page_count_o,
  output logic [ppa_pkg::CNT_W-1:0]   free_total_o
);

  localparam int unsigned PW   = $clog2(POOL_PAGES);
  localparam int unsigned LW   = PW + 1;
  localparam int unsigned RSW  = PW + 1;
  localparam int unsigned IKW  = PW + 2;
  localparam int unsigned NW   = ppa_pkg::BYTES_W + 1 - PAGE_BITS;
  localparam int unsigned FW   = (PW + 1 > ppa_pkg::CNT_W) ? PW + 1 : ppa_pkg::CNT_W;
  localparam int unsigned CW   = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int unsigned CLW  = $clog2(SIZE_CLASSES + 1);
  localparam int unsigned SW   = $clog2(POOL_PAGES + 2);
  localparam logic [LW-1:0] NIL = LW'(POOL_PAGES);
  localparam logic [PW-1:0] LAST_PAGE = PW'(POOL_PAGES - 1);
  localparam logic [CW-1:0] INIT_CLS =
    CW'(ppa_pkg::class_of(32'(POOL_PAGES), 32'(SIZE_CLASSES)));

  // page tables
  logic           sm_mem [POOL_PAGES];
  logic           em_mem [POOL_PAGES];
  logic [RSW-1:0] rs_mem [POOL_PAGES];
  logic [PW-1:0]  ro_mem [POOL_PAGES];
  logic [LW-1:0]  ln_mem [POOL_PAGES];
  logic [LW-1:0]  lp_mem [POOL_PAGES];

  logic           sm_rd_q, em_rd_q;
  logic [RSW-1:0] rs_rd_q;
  logic [PW-1:0]  ro_rd_q;
  logic [LW-1:0]  ln_rd_q, lp_rd_q;

  logic           sm_we, em_we, rs_we, ro_we, ln_we, lp_we;
  logic [PW-1:0]  sm_wa, em_wa, rs_wa, ro_wa, ln_wa, lp_wa;
  logic           sm_wd, em_wd;
  logic [RSW-1:0] rs_wd;
  logic [PW-1:0]  ro_wd;
  logic [LW-1:0]  ln_wd, lp_wd;
  logic           rd_en;
  logic [PW-1:0]  rd_addr;

  // list heads
  logic [LW-1:0] first_q [SIZE_CLASSES];
  logic [LW-1:0] last_q  [SIZE_CLASSES];

  // work registers
  logic                      func_q, out_q, zero_q;
  logic [NW-1:0]             need_q;
  logic [ppa_pkg::ABS_W-1:0] pg_q;
  logic [PW-1:0]             idx_q, cbase_q, j_q, owner_q, clr_q;
  logic [CLW-1:0]            cls_q;
  logic [LW-1:0]             p_q, u_q, ap_q;
  logic [SW-1:0]             steps_q;
  logic [RSW-1:0]            rest_q, n_q, total_q, k_q;
  logic [CW-1:0]             acls_q;
  logic [FW-1:0]             pfree_q;

  logic                      done_q;
  logic [2:0]                status_q;
  logic [ppa_pkg::ABS_W-1:0] page_q;
  logic [ppa_pkg::CNT_W-1:0] count_q, ftot_q;

  logic [ppa_pkg::BYTES_W:0] bsum;
  logic [NW-1:0]             need_in;
  logic [ppa_pkg::ABS_W-1:0] idx_in;
  logic [RSW-1:0]            rest_c, n_c, newsz;
  logic [LW-1:0]             pv, nx, last_sel;
  logic [IKW-1:0]            ik;
  logic                      fit_c;
  ppa_pkg::op_e              op;

  assign op       = cmd_i.op;
  assign bsum     = {1'b0, size_bytes_i} + (ppa_pkg::BYTES_W + 1)'((1 << PAGE_BITS) - 1);
  assign need_in  = bsum[ppa_pkg::BYTES_W:PAGE_BITS];
  assign idx_in   = free_page_i - pool_base_i;
  assign rest_c   = rs_rd_q - RSW'(need_q);
  assign n_c      = {1'b0, j_q} - {1'b0, idx_q} + RSW'(1);
  assign newsz    = rs_rd_q + total_q;
  assign pv       = lp_rd_q;
  assign nx       = ln_rd_q;
  assign last_sel = last_q[acls_q];
  assign ik       = {2'b00, idx_q} + {1'b0, k_q};
  assign fit_c    = 32'(rs_rd_q) >= 32'(need_q);

  always_comb begin
    sts_o.is_free     = func_q;
    sts_o.zero        = zero_q;
    sts_o.outside     = out_q;
    sts_o.no_start    = !sm_rd_q;
    sts_o.cls_end     = (cls_q == CLW'(SIZE_CLASSES));
    sts_o.p_valid     = (p_q < NIL) && (32'(steps_q) <= 32'(POOL_PAGES));
    sts_o.fit         = fit_c;
    sts_o.rest_nz     = (rest_q != '0);
    sts_o.end_found   = em_rd_q || (j_q == LAST_PAGE);
    sts_o.has_next    = (j_q != LAST_PAGE);
    sts_o.next_free   = !sm_rd_q;
    sts_o.idx_nz      = (idx_q != '0);
    sts_o.prev_open   = !em_rd_q;
    sts_o.owner_ne    = (owner_q != idx_q);
    sts_o.owner_small = 32'(rs_rd_q) < 32'(SIZE_CLASSES);
    sts_o.own_more    = (k_q < total_q) && (ik < IKW'(POOL_PAGES));
    sts_o.clr_last    = (clr_q == LAST_PAGE);
  end

  // read port address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (op)
      ppa_pkg::OP_LOAD: begin
        rd_en   = 1'b1;
        rd_addr = idx_in[PW-1:0];
      end
      ppa_pkg::OP_A_P: begin
        rd_en   = 1'b1;
        rd_addr = p_q[PW-1:0];
      end
      ppa_pkg::OP_F_RD: begin
        rd_en   = 1'b1;
        rd_addr = j_q;
      end
      ppa_pkg::OP_F_RDN: begin
        rd_en   = 1'b1;
        rd_addr = j_q + PW'(1);
      end
      ppa_pkg::OP_F_OWN0: begin
        rd_en   = 1'b1;
        rd_addr = idx_q - PW'(1);
      end
      ppa_pkg::OP_F_RDO: begin
        rd_en   = 1'b1;
        rd_addr = owner_q;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  // write ports
  always_comb begin
    sm_we = 1'b0; sm_wa = '0; sm_wd = 1'b0;
    em_we = 1'b0; em_wa = '0; em_wd = 1'b0;
    rs_we = 1'b0; rs_wa = '0; rs_wd = '0;
    ro_we = 1'b0; ro_wa = '0; ro_wd = '0;
    ln_we = 1'b0; ln_wa = '0; ln_wd = '0;
    lp_we = 1'b0; lp_wa = '0; lp_wd = '0;
    case (op)
      ppa_pkg::OP_CLEAR: begin
        sm_we = 1'b1; sm_wa = clr_q;
        em_we = 1'b1; em_wa = clr_q;
        rs_we = 1'b1; rs_wa = clr_q;
        rs_wd = (clr_q == '0) ? RSW'(POOL_PAGES) : '0;
        ro_we = 1'b1; ro_wa = clr_q;
        ln_we = 1'b1; ln_wa = clr_q; ln_wd = NIL;
        lp_we = 1'b1; lp_wa = clr_q; lp_wd = NIL;
      end
      ppa_pkg::OP_A_HIT: begin
        rs_we = 1'b1; rs_wa = p_q[PW-1:0]; rs_wd = rest_c;
      end
      ppa_pkg::OP_A_FIN: begin
        sm_we = 1'b1; sm_wa = cbase_q; sm_wd = 1'b1;
        em_we = 1'b1; em_wa = cbase_q + PW'(need_q) - PW'(1); em_wd = 1'b1;
      end
      ppa_pkg::OP_U1: begin
        ln_we = (pv < NIL); ln_wa = pv[PW-1:0]; ln_wd = nx;
        lp_we = (nx < NIL); lp_wa = nx[PW-1:0]; lp_wd = pv;
      end
      ppa_pkg::OP_U2: begin
        ln_we = 1'b1; ln_wa = u_q[PW-1:0]; ln_wd = NIL;
        lp_we = 1'b1; lp_wa = u_q[PW-1:0]; lp_wd = NIL;
      end
      ppa_pkg::OP_AP0: begin
        ln_we = 1'b1; ln_wa = ap_q[PW-1:0]; ln_wd = NIL;
        lp_we = 1'b1; lp_wa = ap_q[PW-1:0]; lp_wd = last_sel;
      end
      ppa_pkg::OP_AP1: begin
        ln_we = (last_sel < NIL); ln_wa = last_sel[PW-1:0]; ln_wd = ap_q;
      end
      ppa_pkg::OP_F_END: begin
        sm_we = 1'b1; sm_wa = idx_q; sm_wd = 1'b0;
        em_we = 1'b1; em_wa = j_q;   em_wd = 1'b0;
      end
      ppa_pkg::OP_F_SELF: begin
        rs_we = 1'b1; rs_wa = idx_q; rs_wd = total_q;
      end
      ppa_pkg::OP_F_OSUM: begin
        rs_we = 1'b1; rs_wa = owner_q; rs_wd = newsz;
      end
      ppa_pkg::OP_F_WO: begin
        ro_we = 1'b1; ro_wa = ik[PW-1:0]; ro_wd = owner_q;
      end
      default: begin
        sm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) sm_mem[sm_wa] <= sm_wd;
    if (rd_en) sm_rd_q <= sm_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (em_we) em_mem[em_wa] <= em_wd;
    if (rd_en) em_rd_q <= em_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    if (rd_en) rs_rd_q <= rs_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ro_we) ro_mem[ro_wa] <= ro_wd;
    if (rd_en) ro_rd_q <= ro_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ln_we) ln_mem[ln_wa] <= ln_wd;
    if (rd_en) ln_rd_q <= ln_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lp_we) lp_mem[lp_wa] <= lp_wd;
    if (rd_en) lp_rd_q <= lp_mem[rd_addr];
  end

  // control state: list heads, free count, clear sweep, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIZE_CLASSES; i++) begin
        first_q[i] <= (CW'(i) == INIT_CLS) ? '0 : NIL;
        last_q[i]  <= (CW'(i) == INIT_CLS) ? '0 : NIL;
      end
      pfree_q <= FW'(POOL_PAGES);
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (op == ppa_pkg::OP_EMIT);
      case (op)
        ppa_pkg::OP_CLEAR: begin
          clr_q <= clr_q + PW'(1);
        end
        ppa_pkg::OP_U1: begin
          for (int i = 0; i < SIZE_CLASSES; i++) begin
            if (!(pv < NIL) && first_q[i] == u_q) first_q[i] <= nx;
            if (!(nx < NIL) && last_q[i] == u_q) last_q[i] <= pv;
          end
        end
        ppa_pkg::OP_AP1: begin
          if (!(last_sel < NIL)) first_q[acls_q] <= ap_q;
          last_q[acls_q] <= ap_q;
        end
        ppa_pkg::OP_A_FIN: begin
          pfree_q <= pfree_q - FW'(need_q);
        end
        ppa_pkg::OP_F_END: begin
          pfree_q <= pfree_q + FW'(n_c);
        end
        default: begin
          pfree_q <= pfree_q;
        end
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    case (op)
      ppa_pkg::OP_LOAD: begin
        func_q  <= func_i;
        need_q  <= need_in;
        pg_q    <= free_page_i;
        idx_q   <= idx_in[PW-1:0];
        out_q   <= (idx_in >= ppa_pkg::ABS_W'(POOL_PAGES));
        zero_q  <= (size_bytes_i == '0);
        cls_q   <= CLW'(ppa_pkg::class_of(32'(need_in), 32'(SIZE_CLASSES)));
        steps_q <= '0;
      end
      ppa_pkg::OP_A_CLS: begin
        p_q <= first_q[cls_q[CW-1:0]];
      end
      ppa_pkg::OP_A_P: begin
        if ((p_q < NIL) && (32'(steps_q) <= 32'(POOL_PAGES))) begin
          steps_q <= steps_q + SW'(1);
        end else begin
          cls_q <= cls_q + CLW'(1);
        end
      end
      ppa_pkg::OP_A_NEXT: begin
        p_q <= ln_rd_q;
      end
      ppa_pkg::OP_A_HIT: begin
        rest_q  <= rest_c;
        cbase_q <= p_q[PW-1:0] + rest_c[PW-1:0];
        u_q     <= p_q;
        ap_q    <= p_q;
        acls_q  <= CW'(ppa_pkg::class_of(32'(rest_c), 32'(SIZE_CLASSES)));
      end
      ppa_pkg::OP_F_INIT: begin
        j_q <= idx_q;
      end
      ppa_pkg::OP_F_INC: begin
        j_q <= j_q + PW'(1);
      end
      ppa_pkg::OP_F_END: begin
        n_q     <= n_c;
        total_q <= n_c;
        k_q     <= '0;
      end
      ppa_pkg::OP_F_RDN: begin
        u_q <= {1'b0, j_q} + LW'(1);
      end
      ppa_pkg::OP_F_ADDN: begin
        total_q <= total_q + rs_rd_q;
      end
      ppa_pkg::OP_F_OWN0: begin
        owner_q <= idx_q;
      end
      ppa_pkg::OP_F_OWNP: begin
        owner_q <= ro_rd_q;
      end
      ppa_pkg::OP_F_RDO: begin
        u_q <= {1'b0, owner_q};
      end
      ppa_pkg::OP_F_SELF: begin
        ap_q   <= {1'b0, idx_q};
        acls_q <= CW'(ppa_pkg::class_of(32'(total_q), 32'(SIZE_CLASSES)));
      end
      ppa_pkg::OP_F_OSUM: begin
        ap_q   <= {1'b0, owner_q};
        acls_q <= CW'(ppa_pkg::class_of(32'(newsz), 32'(SIZE_CLASSES)));
      end
      ppa_pkg::OP_F_WO: begin
        k_q <= k_q + RSW'(1);
      end
      ppa_pkg::OP_EMIT: begin
        status_q <= cmd_i.st;
        ftot_q   <= pfree_q[ppa_pkg::CNT_W-1:0];
        if (cmd_i.st == ppa_pkg::ST_OK) begin
          page_q  <= func_q ? pg_q : (pool_base_i + ppa_pkg::ABS_W'(cbase_q));
          count_q <= func_q ? ppa_pkg::CNT_W'(n_q) : ppa_pkg::CNT_W'(need_q);
        end else begin
          page_q  <= '0;
          count_q <= '0;
        end
      end
      default: begin
        p_q <= p_q;
      end
    endcase
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign page_o       = page_q;
  assign page_count_o = count_q;
  assign free_total_o = ftot_q;

endmodule

[rtl/ppa_ctrl.sv]
// ----------------------------------------------------------------------------
// Page pool allocator controller
// Sequences the clear sweep, list search, carving, coalescing and result.
// ----------------------------------------------------------------------------
module ppa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  ppa_pkg::sts_t sts_i,
  output ppa_pkg::cmd_t cmd_o
);

  ppa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ppa_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppa_pkg::S_CLEAR: if (sts_i.clr_last) state_d = ppa_pkg::S_IDLE;
      ppa_pkg::S_IDLE:  if (start_i) state_d = ppa_pkg::S_DISP;
      ppa_pkg::S_DISP: begin
        if (sts_i.is_free) begin
          if (sts_i.outside || sts_i.no_start) state_d = ppa_pkg::S_IDLE;
          else state_d = ppa_pkg::S_FSCAN;
        end else begin
          if (sts_i.zero) state_d = ppa_pkg::S_IDLE;
          else state_d = ppa_pkg::S_ACLS;
        end
      end
      ppa_pkg::S_ACLS:  state_d = sts_i.cls_end ? ppa_pkg::S_IDLE : ppa_pkg::S_AP;
      ppa_pkg::S_AP:    state_d = sts_i.p_valid ? ppa_pkg::S_ACHK : ppa_pkg::S_ACLS;
      ppa_pkg::S_ACHK:  state_d = sts_i.fit ? ppa_pkg::S_AU1 : ppa_pkg::S_AP;
      ppa_pkg::S_AU1:   state_d = ppa_pkg::S_AU2;
      ppa_pkg::S_AU2:   state_d = sts_i.rest_nz ? ppa_pkg::S_AA0 : ppa_pkg::S_AFIN;
      ppa_pkg::S_AA0:   state_d = ppa_pkg::S_AA1;
      ppa_pkg::S_AA1:   state_d = ppa_pkg::S_AFIN;
      ppa_pkg::S_AFIN:  state_d = ppa_pkg::S_AEMIT;
      ppa_pkg::S_AEMIT: state_d = ppa_pkg::S_IDLE;
      ppa_pkg::S_FSCAN: state_d = ppa_pkg::S_FCHK;
      ppa_pkg::S_FCHK:  state_d = sts_i.end_found ? ppa_pkg::S_FNX : ppa_pkg::S_FSCAN;
      ppa_pkg::S_FNX:   state_d = sts_i.has_next ? ppa_pkg::S_FNXC : ppa_pkg::S_FPV;
      ppa_pkg::S_FNXC:  state_d = sts_i.next_free ? ppa_pkg::S_FU1 : ppa_pkg::S_FPV;
      ppa_pkg::S_FU1:   state_d = ppa_pkg::S_FU2;
      ppa_pkg::S_FU2:   state_d = ppa_pkg::S_FPV;
      ppa_pkg::S_FPV:   state_d = sts_i.idx_nz ? ppa_pkg::S_FPVC : ppa_pkg::S_FOWN;
      ppa_pkg::S_FPVC:  state_d = ppa_pkg::S_FOWN;
      ppa_pkg::S_FOWN:  state_d = sts_i.owner_ne ? ppa_pkg::S_FOC : ppa_pkg::S_FIA0;
      ppa_pkg::S_FOC:   state_d = sts_i.owner_small ? ppa_pkg::S_OU1 : ppa_pkg::S_FOW;
      ppa_pkg::S_OU1:   state_d = ppa_pkg::S_OU2;
      ppa_pkg::S_OU2:   state_d = ppa_pkg::S_FOSUM;
      ppa_pkg::S_FOSUM: state_d = ppa_pkg::S_FOA0;
      ppa_pkg::S_FOA0:  state_d = ppa_pkg::S_FOA1;
      ppa_pkg::S_FOA1:  state_d = ppa_pkg::S_FOW;
      ppa_pkg::S_FIA0:  state_d = ppa_pkg::S_FIA1;
      ppa_pkg::S_FIA1:  state_d = ppa_pkg::S_FOW;
      ppa_pkg::S_FOW:   if (!sts_i.own_more) state_d = ppa_pkg::S_IDLE;
      default:          state_d = ppa_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o.op = ppa_pkg::OP_NONE;
    cmd_o.st = ppa_pkg::ST_OK;
    case (state_q)
      ppa_pkg::S_CLEAR: cmd_o.op = ppa_pkg::OP_CLEAR;
      ppa_pkg::S_IDLE:  if (start_i) cmd_o.op = ppa_pkg::OP_LOAD;
      ppa_pkg::S_DISP: begin
        if (sts_i.is_free) begin
          if (sts_i.outside) begin
            cmd_o.op = ppa_pkg::OP_EMIT;
            cmd_o.st = ppa_pkg::ST_OUTSIDE;
          end else if (sts_i.no_start) begin
            cmd_o.op = ppa_pkg::OP_EMIT;
            cmd_o.st = ppa_pkg::ST_NOT_START;
          end else begin
            cmd_o.op = ppa_pkg::OP_F_INIT;
          end
        end else if (sts_i.zero) begin
          cmd_o.op = ppa_pkg::OP_EMIT;
          cmd_o.st = ppa_pkg::ST_ZERO;
        end
      end
      ppa_pkg::S_ACLS: begin
        if (sts_i.cls_end) begin
          cmd_o.op = ppa_pkg::OP_EMIT;
          cmd_o.st = ppa_pkg::ST_NO_FIT;
        end else begin
          cmd_o.op = ppa_pkg::OP_A_CLS;
        end
      end
      ppa_pkg::S_AP:    cmd_o.op = ppa_pkg::OP_A_P;
      ppa_pkg::S_ACHK:  cmd_o.op = sts_i.fit ? ppa_pkg::OP_A_HIT : ppa_pkg::OP_A_NEXT;
      ppa_pkg::S_AU1:   cmd_o.op = ppa_pkg::OP_U1;
      ppa_pkg::S_AU2:   cmd_o.op = ppa_pkg::OP_U2;
      ppa_pkg::S_AA0:   cmd_o.op = ppa_pkg::OP_AP0;
      ppa_pkg::S_AA1:   cmd_o.op = ppa_pkg::OP_AP1;
      ppa_pkg::S_AFIN:  cmd_o.op = ppa_pkg::OP_A_FIN;
      ppa_pkg::S_AEMIT: cmd_o.op = ppa_pkg::OP_EMIT;
      ppa_pkg::S_FSCAN: cmd_o.op = ppa_pkg::OP_F_RD;
      ppa_pkg::S_FCHK:  cmd_o.op = sts_i.end_found ? ppa_pkg::OP_F_END : ppa_pkg::OP_F_INC;
      ppa_pkg::S_FNX:   if (sts_i.has_next) cmd_o.op = ppa_pkg::OP_F_RDN;
      ppa_pkg::S_FNXC:  if (sts_i.next_free) cmd_o.op = ppa_pkg::OP_F_ADDN;
      ppa_pkg::S_FU1:   cmd_o.op = ppa_pkg::OP_U1;
      ppa_pkg::S_FU2:   cmd_o.op = ppa_pkg::OP_U2;
      ppa_pkg::S_FPV:   cmd_o.op = ppa_pkg::OP_F_OWN0;
      ppa_pkg::S_FPVC:  if (sts_i.prev_open) cmd_o.op = ppa_pkg::OP_F_OWNP;
      ppa_pkg::S_FOWN:  cmd_o.op = sts_i.owner_ne ? ppa_pkg::OP_F_RDO : ppa_pkg::OP_F_SELF;
      ppa_pkg::S_FOC:   if (!sts_i.owner_small) cmd_o.op = ppa_pkg::OP_F_OSUM;
      ppa_pkg::S_OU1:   cmd_o.op = ppa_pkg::OP_U1;
      ppa_pkg::S_OU2:   cmd_o.op = ppa_pkg::OP_U2;
      ppa_pkg::S_FOSUM: cmd_o.op = ppa_pkg::OP_F_OSUM;
      ppa_pkg::S_FOA0:  cmd_o.op = ppa_pkg::OP_AP0;
      ppa_pkg::S_FOA1:  cmd_o.op = ppa_pkg::OP_AP1;
      ppa_pkg::S_FIA0:  cmd_o.op = ppa_pkg::OP_AP0;
      ppa_pkg::S_FIA1:  cmd_o.op = ppa_pkg::OP_AP1;
      ppa_pkg::S_FOW:   cmd_o.op = sts_i.own_more ? ppa_pkg::OP_F_WO : ppa_pkg::OP_EMIT;
      default:          cmd_o.op = ppa_pkg::OP_NONE;
    endcase
  end

endmodule
